>>> sv/mcpg_pkg.sv
// Shared types and constants for the midpoint circle point generator.
package mcpg_pkg;

  localparam int COORD_WIDTH_DEF  = 12;
  localparam int RADIUS_WIDTH_DEF = 10;

  localparam int DEC_BASE       = 3;
  localparam int DEC_RAD_SCALE  = 2;
  localparam int DEC_STEP_SCALE = 4;
  localparam int DEC_DIAG_BIAS  = 10;
  localparam int DEC_AXIS_BIAS  = 6;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    OCT_PA_PB,
    OCT_NA_PB,
    OCT_PA_NB,
    OCT_NA_NB,
    OCT_PB_PA,
    OCT_NB_PA,
    OCT_PB_NA,
    OCT_NB_NA
  } octant_t;

  typedef struct packed {
    logic point_valid;
    logic last_point;
    logic out_of_range;
  } pt_flags_t;

endpackage

>>> sv/mcpg_req_if.sv
// Request channel: opcode, centre and radius with valid/ready.
interface mcpg_req_if #(
  parameter int COORD_WIDTH  = mcpg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcpg_pkg::RADIUS_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic signed [COORD_WIDTH-1:0]  center_x;
  logic signed [COORD_WIDTH-1:0]  center_y;
  logic        [RADIUS_WIDTH-1:0] radius;

  modport source (output valid, output opcode, output center_x, output center_y,
                  output radius, input ready);
  modport sink (input valid, input opcode, input center_x, input center_y,
                input radius, output ready);
endinterface

>>> sv/mcpg_pt_if.sv
// Point channel: emitted outline point and its flags with valid/ready.
interface mcpg_pt_if #(
  parameter int COORD_WIDTH = mcpg_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          point_valid;
  logic                          last_point;
  logic                          out_of_range;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output last_point, output out_of_range, input ready);
  modport sink (input valid, input point_x, input point_y, input point_valid,
                input last_point, input out_of_range, output ready);
endinterface

>>> sv/mcpg_in_stage.sv
// Input register stage holding one accepted request.
module mcpg_in_stage #(
  parameter int COORD_WIDTH  = mcpg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcpg_pkg::RADIUS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  mcpg_req_if.sink                       req,
  input  logic                           drain,
  output logic                           s_valid,
  output logic                           s_opcode,
  output logic signed [COORD_WIDTH-1:0]  s_center_x,
  output logic signed [COORD_WIDTH-1:0]  s_center_y,
  output logic        [RADIUS_WIDTH-1:0] s_radius
);
  import mcpg_pkg::*;

  logic take;

  assign req.ready = !s_valid || drain;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_opcode   <= req.opcode;
      s_center_x <= req.center_x;
      s_center_y <= req.center_y;
      s_radius   <= req.radius;
    end
  end

endmodule

>>> sv/mcpg_tracer.sv
// Midpoint circle state and point selection for one request per cycle while step is high.
module mcpg_tracer #(
  parameter int COORD_WIDTH  = mcpg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcpg_pkg::RADIUS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           opcode,
  input  logic signed [COORD_WIDTH-1:0]  center_x,
  input  logic signed [COORD_WIDTH-1:0]  center_y,
  input  logic        [RADIUS_WIDTH-1:0] radius,
  output logic signed [COORD_WIDTH-1:0]  point_x,
  output logic signed [COORD_WIDTH-1:0]  point_y,
  output mcpg_pkg::pt_flags_t            flags
);
  import mcpg_pkg::*;

  localparam int OW = RADIUS_WIDTH + 2;
  localparam int DW = RADIUS_WIDTH + 6;
  localparam int SW = ((COORD_WIDTH > OW) ? COORD_WIDTH : OW) + 1;
  localparam logic signed [SW-1:0] XMAX = SW'((1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] XMIN = ~XMAX;

  logic signed [COORD_WIDTH-1:0] centre_col;
  logic signed [COORD_WIDTH-1:0] centre_row;
  logic signed [OW-1:0]          offset_minor;
  logic signed [OW-1:0]          offset_major;
  logic signed [DW-1:0]          decision_value;
  octant_t                       octant_index;
  logic                          busy;

  logic                          start;
  logic                          emit;
  logic signed [COORD_WIDTH-1:0] cur_col;
  logic signed [COORD_WIDTH-1:0] cur_row;
  logic signed [OW-1:0]          cur_a;
  logic signed [OW-1:0]          cur_b;
  logic signed [DW-1:0]          cur_d;
  octant_t                       cur_oct;
  logic signed [OW-1:0]          r_s;
  logic signed [OW-1:0]          dx;
  logic signed [OW-1:0]          dy;
  logic signed [SW-1:0]          sum_x;
  logic signed [SW-1:0]          sum_y;
  logic                          clamp_x;
  logic                          clamp_y;
  logic signed [OW-1:0]          a1;
  logic signed [OW-1:0]          b1;
  logic signed [OW-1:0]          diff;
  logic signed [DW-1:0]          d1;
  logic                          wrap;
  logic                          last;
  logic signed [OW-1:0]          offset_minor_next;
  logic signed [OW-1:0]          offset_major_next;
  logic signed [DW-1:0]          decision_value_next;
  octant_t                       octant_index_next;
  logic                          busy_next;

  always_comb begin
    start   = (opcode == OP_START);
    emit    = start || busy;
    r_s     = signed'({2'b00, radius});
    cur_col = start ? center_x : centre_col;
    cur_row = start ? center_y : centre_row;
    cur_a   = start ? '0 : offset_minor;
    cur_b   = start ? r_s : offset_major;
    cur_d   = start ? (DW'(DEC_BASE) - DW'(DEC_RAD_SCALE) * DW'(r_s)) : decision_value;
    cur_oct = start ? OCT_PA_PB : octant_index;
  end

  always_comb begin
    unique case (cur_oct)
      OCT_PA_PB: begin dx = cur_a;  dy = cur_b;  end
      OCT_NA_PB: begin dx = -cur_a; dy = cur_b;  end
      OCT_PA_NB: begin dx = cur_a;  dy = -cur_b; end
      OCT_NA_NB: begin dx = -cur_a; dy = -cur_b; end
      OCT_PB_PA: begin dx = cur_b;  dy = cur_a;  end
      OCT_NB_PA: begin dx = -cur_b; dy = cur_a;  end
      OCT_PB_NA: begin dx = cur_b;  dy = -cur_a; end
      OCT_NB_NA: begin dx = -cur_b; dy = -cur_a; end
      default:   begin dx = '0;     dy = '0;     end
    endcase
  end

  always_comb begin
    sum_x   = SW'(cur_col) + SW'(dx);
    sum_y   = SW'(cur_row) + SW'(dy);
    clamp_x = (sum_x > XMAX) || (sum_x < XMIN);
    clamp_y = (sum_y > XMAX) || (sum_y < XMIN);
  end

  always_comb begin
    a1   = cur_a + OW'(1);
    b1   = (cur_d > 0) ? (cur_b - OW'(1)) : cur_b;
    diff = a1 - b1;
    if (cur_d > 0) begin
      d1 = cur_d + DW'(DEC_STEP_SCALE) * DW'(diff) + DW'(DEC_DIAG_BIAS);
    end else begin
      d1 = cur_d + DW'(DEC_STEP_SCALE) * DW'(a1) + DW'(DEC_AXIS_BIAS);
    end
    wrap = (cur_oct == OCT_NB_NA);
    last = wrap && (b1 < a1);
  end

  always_comb begin
    offset_minor_next   = cur_a;
    offset_major_next   = cur_b;
    decision_value_next = cur_d;
    octant_index_next   = octant_t'(cur_oct + 3'd1);
    busy_next           = 1'b1;
    if (wrap) begin
      decision_value_next = d1;
      if (last) begin
        offset_minor_next = '0;
        offset_major_next = '0;
        busy_next         = 1'b0;
      end else begin
        offset_minor_next = a1;
        offset_major_next = b1;
      end
    end
  end

  always_comb begin
    if (emit) begin
      point_x            = clamp_x ? XMAX[COORD_WIDTH-1:0] :
                           (sum_x < XMIN) ? XMIN[COORD_WIDTH-1:0] : sum_x[COORD_WIDTH-1:0];
      point_y            = (sum_y > XMAX) ? XMAX[COORD_WIDTH-1:0] :
                           (sum_y < XMIN) ? XMIN[COORD_WIDTH-1:0] : sum_y[COORD_WIDTH-1:0];
      if (sum_x < XMIN) begin
        point_x = XMIN[COORD_WIDTH-1:0];
      end
      flags.point_valid  = 1'b1;
      flags.last_point   = last;
      flags.out_of_range = clamp_x || clamp_y;
    end else begin
      point_x            = '0;
      point_y            = '0;
      flags.point_valid  = 1'b0;
      flags.last_point   = 1'b0;
      flags.out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col     <= '0;
      centre_row     <= '0;
      offset_minor   <= '0;
      offset_major   <= '0;
      decision_value <= '0;
      octant_index   <= OCT_PA_PB;
      busy           <= 1'b0;
    end else if (step && emit) begin
      centre_col     <= cur_col;
      centre_row     <= cur_row;
      offset_minor   <= offset_minor_next;
      offset_major   <= offset_major_next;
      decision_value <= decision_value_next;
      octant_index   <= octant_index_next;
      busy           <= busy_next;
    end
  end

endmodule

>>> sv/midpoint_circle_point_generator_core.sv
// Top level of the midpoint circle point generator.
//
// Channels: req carries one request (opcode, center_x, center_y, radius);
// pt carries exactly one result per request (point_x, point_y, point_valid,
// last_point, out_of_range). Both use valid/ready; a transfer happens on a
// rising edge with valid and ready high.
// A start request loads the centre and radius and returns the first outline
// point; each advance request returns the next of eight mirrored points per
// midpoint step. The final point carries last_point. An advance while no
// circle is active returns a result with point_valid and all fields low.
// The result of a request passes through the input register and then the
// result register before it is offered. Throughput: one request per cycle
// while pt does not stall.
// Reset clears the circle state to idle and empties both registers.
// When pt stalls, the result register holds, the input register fills, and
// req.ready drops only once both are occupied.
module midpoint_circle_point_generator_core #(
  parameter int COORD_WIDTH  = mcpg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mcpg_pkg::RADIUS_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mcpg_req_if.sink   req,
  mcpg_pt_if.source  pt
);
  import mcpg_pkg::*;

  logic                           room;
  logic                           step;
  logic                           s_valid;
  logic                           s_opcode;
  logic signed [COORD_WIDTH-1:0]  s_center_x;
  logic signed [COORD_WIDTH-1:0]  s_center_y;
  logic        [RADIUS_WIDTH-1:0] s_radius;
  logic signed [COORD_WIDTH-1:0]  calc_x;
  logic signed [COORD_WIDTH-1:0]  calc_y;
  pt_flags_t                      calc_flags;
  logic                           out_valid;
  logic signed [COORD_WIDTH-1:0]  out_x;
  logic signed [COORD_WIDTH-1:0]  out_y;
  pt_flags_t                      out_flags;

  assign room = !out_valid || pt.ready;
  assign step = s_valid && room;

  mcpg_in_stage #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .drain      (room),
    .s_valid    (s_valid),
    .s_opcode   (s_opcode),
    .s_center_x (s_center_x),
    .s_center_y (s_center_y),
    .s_radius   (s_radius)
  );

  mcpg_tracer #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_tracer (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .opcode   (s_opcode),
    .center_x (s_center_x),
    .center_y (s_center_y),
    .radius   (s_radius),
    .point_x  (calc_x),
    .point_y  (calc_y),
    .flags    (calc_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_x     <= calc_x;
      out_y     <= calc_y;
      out_flags <= calc_flags;
    end
  end

  assign pt.valid        = out_valid;
  assign pt.point_x      = out_x;
  assign pt.point_y      = out_y;
  assign pt.point_valid  = out_flags.point_valid;
  assign pt.last_point   = out_flags.last_point;
  assign pt.out_of_range = out_flags.out_of_range;

endmodule

>>> sv/mcpg_checker.sv
// Port-level checks for the midpoint circle point generator, bound to the top level.
module mcpg_checker #(
  parameter int COORD_WIDTH = mcpg_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          pt_valid,
  input logic                          pt_ready,
  input logic signed [COORD_WIDTH-1:0] point_x,
  input logic signed [COORD_WIDTH-1:0] point_y,
  input logic                          point_valid,
  input logic                          last_point,
  input logic                          out_of_range
);
  import mcpg_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_ready |=> pt_valid && $stable(point_x) && $stable(point_y)
      && $stable(last_point))
    else $error("result changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !point_valid |-> point_x == '0 && point_y == '0 && !last_point
      && !out_of_range)
    else $error("idle result carries nonzero fields");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    pt_valid && last_point |-> point_valid)
    else $error("last point marked on idle result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pt_valid)
    else $error("result offered right after reset");

endmodule

bind midpoint_circle_point_generator_core mcpg_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_mcpg_checker (
  .clk          (clk),
  .rst          (rst),
  .pt_valid     (pt.valid),
  .pt_ready     (pt.ready),
  .point_x      (pt.point_x),
  .point_y      (pt.point_y),
  .point_valid  (pt.point_valid),
  .last_point   (pt.last_point),
  .out_of_range (pt.out_of_range)
);

>>> tb/sv/tb_mcpg_point_checker.sv
// Watches both channels, predicts each outline point and compares it with the one returned.
module tb_mcpg_point_checker (
  input  logic clk,
  input  logic rst,
  mcpg_req_if  req,
  mcpg_pt_if   pt,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mcpg_pkg::*;

  localparam int CW       = COORD_WIDTH_DEF;
  localparam int RW       = RADIUS_WIDTH_DEF;
  localparam int COORD_HI = 2 ** (CW - 1) - 1;
  localparam int COORD_LO = -(2 ** (CW - 1));

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    pt_flags_t            flags;
  } outline_point_t;

  outline_point_t       expected_points[$];
  logic signed [CW-1:0] centre_col;
  logic signed [CW-1:0] centre_row;
  int                   minor_off;
  int                   major_off;
  int                   decision;
  octant_t              octant;
  logic                 tracing;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic signed [CW-1:0] saturate(input int v, inout logic hit);
    if (v > COORD_HI) begin
      hit = 1'b1;
      return CW'(COORD_HI);
    end
    if (v < COORD_LO) begin
      hit = 1'b1;
      return CW'(COORD_LO);
    end
    return CW'(v);
  endfunction

  function automatic outline_point_t predict_point(input opcode_t op,
                                                   input logic signed [CW-1:0] cx,
                                                   input logic signed [CW-1:0] cy,
                                                   input logic [RW-1:0] rad);
    outline_point_t p;
    int             dx;
    int             dy;
    logic           hit;
    p.x     = '0;
    p.y     = '0;
    p.flags = '0;
    hit     = 1'b0;
    if (op == OP_START) begin
      centre_col = cx;
      centre_row = cy;
      minor_off  = 0;
      major_off  = int'(rad);
      decision   = DEC_BASE - DEC_RAD_SCALE * int'(rad);
      octant     = OCT_PA_PB;
      tracing    = 1'b1;
    end else if (!tracing) begin
      return p;
    end
    case (octant)
      OCT_PA_PB: begin dx =  minor_off; dy =  major_off; end
      OCT_NA_PB: begin dx = -minor_off; dy =  major_off; end
      OCT_PA_NB: begin dx =  minor_off; dy = -major_off; end
      OCT_NA_NB: begin dx = -minor_off; dy = -major_off; end
      OCT_PB_PA: begin dx =  major_off; dy =  minor_off; end
      OCT_NB_PA: begin dx = -major_off; dy =  minor_off; end
      OCT_PB_NA: begin dx =  major_off; dy = -minor_off; end
      default:   begin dx = -major_off; dy = -minor_off; end
    endcase
    p.x                  = saturate(int'(centre_col) + dx, hit);
    p.y                  = saturate(int'(centre_row) + dy, hit);
    p.flags.point_valid  = 1'b1;
    p.flags.out_of_range = hit;
    if (octant == OCT_NB_NA) begin
      minor_off++;
      if (decision > 0) begin
        major_off--;
        decision += DEC_STEP_SCALE * (minor_off - major_off) + DEC_DIAG_BIAS;
      end else begin
        decision += DEC_STEP_SCALE * minor_off + DEC_AXIS_BIAS;
      end
      octant = OCT_PA_PB;
      if (major_off < minor_off) begin
        p.flags.last_point = 1'b1;
        tracing            = 1'b0;
        minor_off          = 0;
        major_off          = 0;
      end
    end else begin
      octant = octant_t'(octant + 3'd1);
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    outline_point_t want;
    outline_point_t got;
    if (rst) begin
      expected_points.delete();
      centre_col = '0;
      centre_row = '0;
      minor_off  = 0;
      major_off  = 0;
      decision   = 0;
      octant     = OCT_PA_PB;
      tracing    = 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_points.push_back(predict_point(opcode_t'(req.opcode), req.center_x,
                                                req.center_y, req.radius));
      end
      if (pt.valid && pt.ready) begin
        got.x     = pt.point_x;
        got.y     = pt.point_y;
        got.flags = {pt.point_valid, pt.last_point, pt.out_of_range};
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: point with no request waiting: x=%0d y=%0d flags=%b",
                     $time, got.x, got.y, got.flags);
          end
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.flags !== want.flags) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: point mismatch: expected x=%0d y=%0d flags=%b, got x=%0d y=%0d flags=%b",
                       $time, want.x, want.y, want.flags, got.x, got.y, got.flags);
            end
          end
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

>>> tb/sv/tb_midpoint_circle_point_generator_core.sv
// Top of the circle point generator regression: clock, reset, request stimulus and verdict.
module tb_midpoint_circle_point_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mcpg_pkg::*;

  localparam int CW              = COORD_WIDTH_DEF;
  localparam int RW              = RADIUS_WIDTH_DEF;
  localparam int ITEM_TARGET     = 1350;
  localparam int HOLD_OFF_CYCLES = 200;

  localparam logic signed [CW-1:0] X_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] X_MIN = {1'b1, {(CW-1){1'b0}}};

  logic clk           = 1'b0;
  logic rst           = 1'b1;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;
  logic quiet         = 1'b0;
  int   fail_count;
  int   pending;
  int   sent_count    = 0;
  int   tx_calm_left  = 0;

  mcpg_req_if req_ch ();
  mcpg_pt_if  pt_ch ();

  midpoint_circle_point_generator_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pt  (pt_ch)
  );

  tb_mcpg_point_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .pt         (pt_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("midpoint_circle_point_generator_core regression: fail");
    $finish;
  end

  function automatic logic signed [CW-1:0] any_coord();
    return CW'($urandom);
  endfunction

  function automatic int outline_length(input int rad);
    int a     = 0;
    int b     = rad;
    int d     = 3 - 2 * rad;
    int steps = 0;
    do begin
      a++;
      if (d > 0) begin
        b--;
        d += 4 * (a - b) + 10;
      end else begin
        d += 4 * a + 6;
      end
      steps++;
    end while (b >= a);
    return 8 * steps;
  endfunction

  task automatic offer_request(input opcode_t op, input logic signed [CW-1:0] cx,
                               input logic signed [CW-1:0] cy, input logic [RW-1:0] rad);
    @(negedge clk);
    req_ch.valid    = 1'b1;
    req_ch.opcode   = op;
    req_ch.center_x = cx;
    req_ch.center_y = cy;
    req_ch.radius   = rad;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  task automatic sender_idle();
    int pick;
    int gap;
    if (quiet) return;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return;
    end
    pick = $urandom_range(0, 31);
    if (pick == 0) begin
      tx_calm_left = $urandom_range(20, 100);
    end else if (pick < 5) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_points();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic send_advance();
    sender_idle();
    offer_request(OP_ADVANCE, any_coord(), any_coord(), RW'($urandom));
  endtask

  task automatic send_circle(input logic [RW-1:0] rad, input int n_adv);
    sender_idle();
    offer_request(OP_START, any_coord(), any_coord(), rad);
    repeat (n_adv) send_advance();
  endtask

  initial begin : drive_pt_ready
    int stall_left;
    int calm_left;
    int pick;
    stall_left  = 0;
    calm_left   = 0;
    pt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pt_ch.ready = 1'b0;
      end else if (hold_off_req && !hold_off_done) begin
        pt_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_done = 1'b1;
      end else if (quiet) begin
        pt_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        pt_ch.ready = 1'b0;
        stall_left--;
      end else begin
        pt_ch.ready = 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          pick = $urandom_range(0, 15);
          if (pick == 0) calm_left = $urandom_range(20, 100);
          else if (pick < 4) stall_left = $urandom_range(1, 16);
        end
      end
    end
  end

  initial begin : stimulus
    int             kind;
    int             len;
    logic [RW-1:0]  rad;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_START;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.radius   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer_request(OP_ADVANCE, X_MAX, X_MIN, '1);
    offer_request(OP_START, X_MAX, X_MIN, '0);
    repeat (7) offer_request(OP_ADVANCE, '0, '0, '0);
    offer_request(OP_START, X_MIN, X_MAX, '1);
    repeat (6) offer_request(OP_ADVANCE, X_MIN, X_MAX, '1);
    offer_request(OP_START, '0, '0, RW'(1));
    repeat (7) offer_request(OP_ADVANCE, '0, '0, '0);
    offer_request(OP_ADVANCE, '0, '0, '0);
    drain_points();

    while (sent_count < ITEM_TARGET) begin
      if (sent_count > 400) hold_off_req = 1'b1;
      if (sent_count > 1150) quiet = 1'b1;
      if (sent_count > 800 && sent_count < 830) drain_points();
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          repeat ($urandom_range(1, 4)) send_advance();
        end
        1: begin
          rad = RW'($urandom);
          len = outline_length(rad);
          send_circle(rad, $urandom_range(0, (len > 32) ? 30 : len - 2));
        end
        2: begin
          rad = RW'($urandom_range(0, 12));
          send_circle(rad, outline_length(rad) - 1 + $urandom_range(1, 3));
        end
        default: begin
          if ($urandom_range(0, 15) == 0) rad = RW'($urandom_range(13, 48));
          else rad = RW'($urandom_range(0, 12));
          send_circle(rad, outline_length(rad) - 1);
        end
      endcase
    end

    drain_points();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("midpoint_circle_point_generator_core regression: pass");
    end else begin
      $display("midpoint_circle_point_generator_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/mcpg_pkg.sv
sv/mcpg_req_if.sv
sv/mcpg_pt_if.sv
sv/mcpg_in_stage.sv
sv/mcpg_tracer.sv
sv/midpoint_circle_point_generator_core.sv
sv/mcpg_checker.sv
tb/sv/tb_mcpg_point_checker.sv
tb/sv/tb_midpoint_circle_point_generator_core.sv
